@@ hw/rtl/piq_pkg.sv @@
// ----------------------------------------------------------------------------
// piq_pkg
// Shared types, opcodes and status codes for the positional insert queue.
// ----------------------------------------------------------------------------
package piq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 64;
  localparam int POS_W         = 8;
  localparam int COUNT_OUT_W   = 5;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] name_word;
    logic [WORD_W-1:0] id_word;
  } rec_t;

  // Shift command broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;  // open a gap at the insert index and load the new record
    logic pop;  // every cell takes its right neighbor's record
  } cmd_t;

endpackage

@@ hw/rtl/positional_insert_queue.sv @@
// ----------------------------------------------------------------------------
// positional_insert_queue
// Ordered record queue with append, insert at a 1-based position and pop.
// Each result item is registered as its item is accepted. Throughput:
// one item per cycle unless out_ready stalls; every cell of the chain
// shifts in the same cycle, so the single output register is the only
// pacing element. Reset: synchronous active-low rst_n empties the queue
// and out_valid; record contents are not cleared and need no such pass.
// ----------------------------------------------------------------------------
module positional_insert_queue #(
  parameter int DEPTH = piq_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_op,
  input  logic [piq_pkg::POS_W-1:0]       in_position,
  input  logic [piq_pkg::WORD_W-1:0]      in_name_word,
  input  logic [piq_pkg::WORD_W-1:0]      in_id_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_popped_valid,
  output logic [piq_pkg::WORD_W-1:0]      out_popped_name,
  output logic [piq_pkg::WORD_W-1:0]      out_popped_id,
  output logic [piq_pkg::COUNT_OUT_W-1:0] out_entry_count,
  output logic                            out_queue_empty,
  output logic [1:0]                      out_status
);
  import piq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  cmd_t          cmd;
  logic [IW-1:0] idx;
  rec_t          new_rec;
  rec_t          cell_rec [DEPTH];

  assign new_rec.name_word = in_name_word;
  assign new_rec.id_word   = in_id_word;

  // The control block decides, for each accepted item, whether the chain
  // opens a gap (insert or append, with the gap at idx) or closes the head
  // (pop). The head cell's record is captured into the result on a pop.
  piq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_position     (in_position),
    .head_rec        (cell_rec[0]),
    .cmd             (cmd),
    .idx             (idx),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_popped_valid(out_popped_valid),
    .out_popped_name (out_popped_name),
    .out_popped_id   (out_popped_id),
    .out_entry_count (out_entry_count),
    .out_queue_empty (out_queue_empty),
    .out_status      (out_status)
  );

  // Cell k holds the record at queue place k, the head being cell 0. On an
  // insert, cells above the gap take their left neighbor's record; on a
  // pop, every cell takes its right neighbor's. The ends of the chain are
  // fed with don't-care records, which land only in slots beyond the count.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    rec_t prev_rec;
    rec_t next_rec;

    if (k == 0) begin : g_first
      assign prev_rec = new_rec;
    end else begin : g_mid_prev
      assign prev_rec = cell_rec[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign next_rec = new_rec;
    end else begin : g_mid_next
      assign next_rec = cell_rec[k+1];
    end

    piq_cell #(
      .IDX(k),
      .IW (IW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (idx),
      .new_rec (new_rec),
      .prev_rec(prev_rec),
      .next_rec(next_rec),
      .rec     (cell_rec[k])
    );
  end

endmodule

@@ hw/rtl/piq_cell.sv @@
// ----------------------------------------------------------------------------
// piq_cell
// One slot of the queue: holds a record and takes it from its neighbor,
// from the incoming item, or keeps it, as the broadcast command says.
// ----------------------------------------------------------------------------
module piq_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4
) (
  input  logic          clk,
  input  piq_pkg::cmd_t cmd,
  input  logic [IW-1:0] idx,
  input  piq_pkg::rec_t new_rec,
  input  piq_pkg::rec_t prev_rec,
  input  piq_pkg::rec_t next_rec,
  output piq_pkg::rec_t rec
);
  import piq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (idx == MY_IDX) begin
        rec_r <= new_rec;
      end else if (MY_IDX > idx) begin
        rec_r <= prev_rec;
      end
    end else if (cmd.pop) begin
      rec_r <= next_rec;
    end
  end

  assign rec = rec_r;

endmodule

@@ hw/rtl/piq_ctrl.sv @@
// ----------------------------------------------------------------------------
// piq_ctrl
// Decodes each item against the held count, drives the cell chain command
// and registers the result item.
// ----------------------------------------------------------------------------
module piq_ctrl #(
  parameter int DEPTH = piq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [piq_pkg::POS_W-1:0]         in_position,
  input  piq_pkg::rec_t                     head_rec,
  output piq_pkg::cmd_t                     cmd,
  output logic [$clog2(DEPTH)-1:0]          idx,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_popped_valid,
  output logic [piq_pkg::WORD_W-1:0]        out_popped_name,
  output logic [piq_pkg::WORD_W-1:0]        out_popped_id,
  output logic [piq_pkg::COUNT_OUT_W-1:0]   out_entry_count,
  output logic                              out_queue_empty,
  output logic [1:0]                        out_status
);
  import piq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r;
  logic            popped_valid_r;
  rec_t            popped_r;
  logic [COUNT_OUT_W-1:0] count_out_r;
  logic            empty_r;
  logic [1:0]      status_r;

  logic            fire;
  logic [1:0]      status_nxt;
  logic            do_pop;
  logic [CMPW-1:0] pos_ext, cnt_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign pos_ext  = CMPW'(in_position);
  assign cnt_ext  = CMPW'(cnt_r);

  always_comb begin
    cmd        = '0;
    idx        = cnt_r[IW-1:0];
    status_nxt = ST_DONE;
    do_pop     = 1'b0;
    cnt_nxt    = cnt_r;
    priority if (in_op == OP_APPEND || in_op == OP_INSERT) begin
      if (cnt_r == CW'(DEPTH)) begin
        status_nxt = ST_FULL;
      end else if (in_op == OP_APPEND || cnt_r == '0) begin
        cmd.ins = 1'b1;
      end else if (in_position == '0) begin
        status_nxt = ST_IGNORED;
      end else if (pos_ext > cnt_ext) begin
        cmd.ins = 1'b1;
      end else begin
        cmd.ins = 1'b1;
        idx     = IW'(in_position - POS_W'(1));
      end
    end else if (in_op == OP_POP) begin
      if (cnt_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        cmd.pop = 1'b1;
        do_pop  = 1'b1;
      end
    end else begin
      status_nxt = ST_IGNORED;
    end
    if (!fire) begin
      cmd = '0;
    end
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      popped_valid_r <= do_pop;
      popped_r       <= do_pop ? head_rec : '0;
      count_out_r    <= COUNT_OUT_W'(cnt_nxt);
      empty_r        <= (cnt_nxt == '0);
      status_r       <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_valid = popped_valid_r;
  assign out_popped_name  = popped_r.name_word;
  assign out_popped_id    = popped_r.id_word;
  assign out_entry_count  = count_out_r;
  assign out_queue_empty  = empty_r;
  assign out_status       = status_r;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert queue. A scoreboard class
// mirrors the queue contents, predicts one result item for every accepted
// input item and checks the results in order. Plain tasks drive a directed
// opening sequence and then phases of random traffic that fill, drain and
// churn the queue, with random idling on both handshake sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import piq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // The opcode field is two bits wide, but only three codes are defined.
  // The fourth one must leave the queue alone and report that it was ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1050;
  // The result register holds back each result item; the drain lets stray
  // items show up before the verdict.
  localparam int DRAIN_CYCLES = 8;
  // Worst case is roughly 1100 items, each waiting out the longest send gap
  // and the longest receive stall, so this is several times the slowest run.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 12;

  // Random traffic runs in phases so that the queue regularly reaches both
  // the full and the empty state instead of hovering around the middle.
  typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_e;

  // One result item as the block presents it on the output side.
  typedef struct packed {
    logic                   popped_valid;
    logic [WORD_W-1:0]      popped_name;
    logic [WORD_W-1:0]      popped_id;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   queue_empty;
    logic [1:0]             status;
  } outcome_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the ordered records and a queue of the
  // result items still owed by the block.
  // --------------------------------------------------------------------------
  class queue_scoreboard;
    rec_t     records[$];
    outcome_t owed_results[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function int held();
      return records.size();
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // Applies one accepted input item to the mirrored queue and records the
    // result item the block has to produce for it.
    function void note_item(logic [1:0] op, logic [POS_W-1:0] pos, rec_t rec);
      outcome_t res;
      res        = '0;
      res.status = ST_DONE;
      case (op)
        OP_APPEND, OP_INSERT: begin
          // The full check wins over every position rule.
          if (records.size() >= DEPTH) begin
            res.status = ST_FULL;
          end else if (op == OP_APPEND || records.size() == 0 ||
                       int'(pos) > records.size()) begin
            // Appends, any insert into an empty queue, and inserts past the
            // count all land at the tail.
            records.push_back(rec);
          end else if (pos == '0) begin
            res.status = ST_IGNORED;
          end else begin
            records.insert(int'(pos) - 1, rec);
          end
        end
        OP_POP: begin
          if (records.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped_valid = 1'b1;
            res.popped_name  = records[0].name_word;
            res.popped_id    = records[0].id_word;
            void'(records.pop_front());
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
      res.entry_count = COUNT_OUT_W'(records.size());
      res.queue_empty = (records.size() == 0);
      owed_results.push_back(res);
    endfunction

    function void check_field(string field, logic [WORD_W-1:0] want,
                              logic [WORD_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h",
                 $time, field, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result item against the oldest expectation.
    function void check_result(outcome_t got);
      outcome_t want;
      if (owed_results.size() == 0) begin
        $display("%0t ns: result item with no expectation, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      check_field("popped_valid", WORD_W'(want.popped_valid), WORD_W'(got.popped_valid));
      check_field("popped_name", want.popped_name, got.popped_name);
      check_field("popped_id", want.popped_id, got.popped_id);
      check_field("entry_count", WORD_W'(want.entry_count), WORD_W'(got.entry_count));
      check_field("queue_empty", WORD_W'(want.queue_empty), WORD_W'(got.queue_empty));
      check_field("status", WORD_W'(want.status), WORD_W'(got.status));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [1:0]             in_op        = OP_APPEND;
  logic [POS_W-1:0]       in_position  = '0;
  logic [WORD_W-1:0]      in_name_word = '0;
  logic [WORD_W-1:0]      in_id_word   = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic                   out_popped_valid;
  logic [WORD_W-1:0]      out_popped_name;
  logic [WORD_W-1:0]      out_popped_id;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic                   out_queue_empty;
  logic [1:0]             out_status;

  // Each side switches now and then into a stretch without any idling.
  bit send_burst = 1'b0;
  bit sink_burst = 1'b0;

  queue_scoreboard sb = new();

  always #2 clk = ~clk;

  positional_insert_queue #(.DEPTH(DEPTH)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_name_word     (in_name_word),
    .in_id_word       (in_id_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_valid (out_popped_valid),
    .out_popped_name  (out_popped_name),
    .out_popped_id    (out_popped_id),
    .out_entry_count  (out_entry_count),
    .out_queue_empty  (out_queue_empty),
    .out_status       (out_status)
  );

  // Draws the idle cycles before the next item on one side. Occasionally the
  // side flips between normal idling and a burst with no idling at all.
  function automatic int pick_gap(inout bit burst);
    if ($urandom_range(0, 39) == 0) begin
      burst = ~burst;
    end
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Record words lean toward the all-zero and all-one extremes now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  // Presents one item and waits for the handshake. The task is always entered
  // right after a rising edge. Valid is only lowered when a gap follows, so a
  // back-to-back item never sees valid dropped and raised in the same step.
  task automatic send_item(input logic [1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] name_word,
                           input logic [WORD_W-1:0] id_word);
    int   gap;
    rec_t rec;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_position  <= pos;
    in_name_word <= name_word;
    in_id_word   <= id_word;
    // Signals are read right after the edge, so they hold the values that the
    // block saw at that edge.
    do @(posedge clk); while (!in_ready);
    rec.name_word = name_word;
    rec.id_word   = id_word;
    sb.note_item(op, pos, rec);
  endtask

  // The opening sequence walks through every operation and every corner of
  // the position rules, then fills the queue to test the full rejection.
  task automatic run_directed();
    int fill_step;
    // Pop and the unused opcode on an empty queue.
    send_item(OP_POP, 8'd0, '0, '0);
    send_item(OP_UNUSED, 8'd5, '1, '1);
    // On an empty queue even position zero inserts.
    send_item(OP_INSERT, 8'd0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_item(OP_POP, 8'd0, '0, '0);
    // Largest position on an empty queue, then word extremes.
    send_item(OP_INSERT, 8'd255, '1, '0);
    send_item(OP_APPEND, 8'd0, '0, '1);
    // Insert at the head, then position zero on a non-empty queue is ignored.
    send_item(OP_INSERT, 8'd1, 64'h1111_0000_1111_0000, 64'h0000_2222_0000_2222);
    send_item(OP_INSERT, 8'd0, 64'hdead_beef_dead_beef, 64'hbeef_dead_beef_dead);
    // Middle insert, far past the count, one past the count, and just
    // in front of the tail.
    send_item(OP_INSERT, 8'd2, pick_word(), pick_word());
    send_item(OP_INSERT, 8'd255, pick_word(), pick_word());
    send_item(OP_INSERT, 8'd6, pick_word(), pick_word());
    send_item(OP_INSERT, 8'd6, pick_word(), pick_word());
    send_item(OP_UNUSED, 8'd0, pick_word(), pick_word());
    send_item(OP_POP, 8'd0, '0, '0);
    // Fill the queue, mixing appends with inserts at random places.
    fill_step = 0;
    while (sb.held() < DEPTH) begin
      if (fill_step[0]) begin
        send_item(OP_INSERT, POS_W'($urandom_range(1, sb.held())), pick_word(), pick_word());
      end else begin
        send_item(OP_APPEND, 8'd0, pick_word(), pick_word());
      end
      fill_step++;
    end
    // Both kinds of add are rejected when full, even with position zero.
    send_item(OP_APPEND, 8'd3, pick_word(), pick_word());
    send_item(OP_INSERT, 8'd0, pick_word(), pick_word());
    send_item(OP_POP, 8'd0, '0, '0);
    // With one slot free, a position equal to the depth appends.
    send_item(OP_INSERT, POS_W'(DEPTH), pick_word(), pick_word());
  endtask

  // Random traffic in phases that favor adds, pops, or neither. Positions are
  // mostly valid places in the current queue, with zero and the full 8-bit
  // range mixed in.
  task automatic run_random();
    int               counted;
    int               phase_left;
    int               add_share;
    int               roll;
    phase_e           phase;
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    counted    = 0;
    phase_left = 0;
    phase      = MIXED_PHASE;
    add_share  = 50;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        phase      = phase_e'($urandom_range(0, 2));
        case (phase)
          FILL_PHASE:  add_share = 80;
          DRAIN_PHASE: add_share = 25;
          default:     add_share = 50;
        endcase
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (roll < add_share) begin
        op = ($urandom_range(0, 1) != 0) ? OP_INSERT : OP_APPEND;
      end else begin
        op = OP_POP;
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        pos = POS_W'($urandom_range(1, sb.held() + 1));
      end else if (roll < 80) begin
        pos = '0;
      end else begin
        pos = POS_W'($urandom);
      end
      send_item(op, pos, pick_word(), pick_word());
      counted++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stalls at random, then takes and checks each result item.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int     gap;
    outcome_t got;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap(sink_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.popped_valid = out_popped_valid;
      got.popped_name  = out_popped_name;
      got.popped_id    = out_popped_id;
      got.entry_count  = out_entry_count;
      got.queue_empty  = out_queue_empty;
      got.status       = out_status;
      sb.check_result(got);
    end
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset once, directed items, random items, then drain.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t ns: %0d result items never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
